// File: hdl/rqs_pkg.sv
`default_nettype none
package rqs_pkg;

  localparam int CAPACITY = 64;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [15:0] record_tag;
    logic [15:0] train_number;
    logic        is_arrival;
    logic [31:0] plan_seconds;
    logic        final_record;
  } item_t;

  typedef struct packed {
    logic [15:0] out_tag;
    logic [15:0] out_train;
    logic        out_arrival;
    logic [31:0] out_seconds;
    logic        dropped_flag;
    logic        end_of_run;
  } result_t;

  typedef struct packed {
    logic [15:0] train;
    logic        arrival;
    logic [31:0] seconds;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic [AW-1:0] lo;
    logic [AW-1:0] hi;
  } range_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_INIT, ST_POP, ST_POP_D, ST_PIV, ST_FWD, ST_BWD, ST_CHECK,
    ST_SWAP1, ST_SWAP2, ST_PLACE1, ST_PLACE2, ST_PUSH_R, ST_PUSH_L,
    ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_LOAD, OP_INIT, OP_POP, OP_POP_D, OP_PIV, OP_FWD, OP_BWD, OP_NONE,
    OP_SWAP1, OP_SWAP2, OP_PLACE1, OP_PLACE2, OP_PUSH_R, OP_PUSH_L,
    OP_OUT_RD, OP_OUT_LD, OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_ready;
  } cmd_t;

  typedef struct packed {
    logic final_taken;
    logic sp_zero;
    logic range_empty;
    logic fwd_le;
    logic i_next_hi;
    logic bwd_le;
    logic j_next_lo;
    logic i_ge_j;
    logic out_taken;
    logic out_last;
  } status_t;

  // not a strict order: differing trains fall back to time alone
  function automatic logic at_or_before(input key_t a, input key_t b);
    if (a.train == b.train && a.arrival != b.arrival) begin
      return a.arrival;
    end
    return a.seconds <= b.seconds;
  endfunction

endpackage
`default_nettype wire

// File: hdl/rqs_ram.sv
`default_nettype none
module rqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/rqs_ctrl.sv
`default_nettype none
module rqs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rqs_pkg::status_t status,
  output rqs_pkg::cmd_t         cmd
);
  import rqs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:     if (status.final_taken) state_next = ST_INIT;
      ST_INIT:     state_next = ST_POP;
      ST_POP:      state_next = status.sp_zero ? ST_OUT_RD : ST_POP_D;
      ST_POP_D:    state_next = status.range_empty ? ST_POP : ST_PIV;
      ST_PIV:      state_next = ST_FWD;
      ST_FWD:      state_next = (status.fwd_le && !status.i_next_hi) ? ST_FWD : ST_BWD;
      ST_BWD:      state_next = (status.bwd_le && !status.j_next_lo) ? ST_BWD : ST_CHECK;
      ST_CHECK:    state_next = status.i_ge_j ? ST_PLACE1 : ST_SWAP1;
      ST_SWAP1:    state_next = ST_SWAP2;
      ST_SWAP2:    state_next = ST_FWD;
      ST_PLACE1:   state_next = ST_PLACE2;
      ST_PLACE2:   state_next = ST_PUSH_R;
      ST_PUSH_R:   state_next = ST_PUSH_L;
      ST_PUSH_L:   state_next = ST_POP;
      ST_OUT_RD:   state_next = ST_OUT_LD;
      ST_OUT_LD:   state_next = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (status.out_taken) state_next = status.out_last ? ST_DONE : ST_OUT_RD;
      end
      ST_DONE:     state_next = ST_LOAD;
      default:     state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd.load_ready = 1'b0;
    cmd.op         = OP_NONE;
    unique case (state)
      ST_LOAD: begin
        cmd.op         = OP_LOAD;
        cmd.load_ready = 1'b1;
      end
      ST_INIT:     cmd.op = OP_INIT;
      ST_POP:      cmd.op = OP_POP;
      ST_POP_D:    cmd.op = OP_POP_D;
      ST_PIV:      cmd.op = OP_PIV;
      ST_FWD:      cmd.op = OP_FWD;
      ST_BWD:      cmd.op = OP_BWD;
      ST_CHECK:    cmd.op = OP_NONE;
      ST_SWAP1:    cmd.op = OP_SWAP1;
      ST_SWAP2:    cmd.op = OP_SWAP2;
      ST_PLACE1:   cmd.op = OP_PLACE1;
      ST_PLACE2:   cmd.op = OP_PLACE2;
      ST_PUSH_R:   cmd.op = OP_PUSH_R;
      ST_PUSH_L:   cmd.op = OP_PUSH_L;
      ST_OUT_RD:   cmd.op = OP_OUT_RD;
      ST_OUT_LD:   cmd.op = OP_OUT_LD;
      ST_OUT_HOLD: cmd.op = OP_NONE;
      ST_DONE:     cmd.op = OP_DONE;
      default:     cmd.op = OP_NONE;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/rqs_dp.sv
`default_nettype none
module rqs_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rqs_pkg::cmd_t    cmd,
  output rqs_pkg::status_t      status,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire rqs_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output rqs_pkg::result_t      result
);
  import rqs_pkg::*;

  logic [CW-1:0] count;
  logic          overflow;
  logic [CW-1:0] sp;
  logic [AW-1:0] lo, hi, i, j, k;
  entry_t        pivot, ival, jval;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr;
  range_t        stk_wdata, stk_rdata;

  logic          accept;
  logic          has_room;
  logic [AW:0]   i_inc, j_inc, lo_inc;
  logic [CW-1:0] count_dec;

  rqs_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_records (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  rqs_ram #(.WIDTH($bits(range_t)), .DEPTH(CAPACITY)) u_ranges (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign item_ready = cmd.load_ready;
  assign accept     = item_valid && item_ready;
  assign has_room   = count < CW'(CAPACITY);
  assign i_inc      = {1'b0, i} + 1'b1;
  assign j_inc      = {1'b0, j} + 1'b1;
  assign lo_inc     = {1'b0, lo} + 1'b1;
  assign count_dec  = count - 1'b1;

  always_comb begin
    status.final_taken = accept && item.final_record;
    status.sp_zero     = sp == '0;
    status.range_empty = stk_rdata.hi <= stk_rdata.lo;
    status.fwd_le      = at_or_before(mem_rdata.key, pivot.key);
    status.i_next_hi   = i_inc == {1'b0, hi};
    status.bwd_le      = at_or_before(pivot.key, mem_rdata.key);
    status.j_next_lo   = {1'b0, j} == lo_inc;
    status.i_ge_j      = i >= j;
    status.out_taken   = result_valid && result_ready;
    status.out_last    = result.end_of_run;
  end

  // ram ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i;
    mem_wdata = jval;
    mem_raddr = k;
    stk_we    = 1'b0;
    stk_waddr = sp[AW-1:0];
    stk_wdata = '{lo: lo, hi: hi};
    stk_raddr = sp[AW-1:0] - 1'b1;
    case (cmd.op)
      OP_LOAD: begin
        mem_we    = accept && has_room;
        mem_waddr = count[AW-1:0];
        mem_wdata = '{key: '{train: item.train_number, arrival: item.is_arrival,
                             seconds: item.plan_seconds}, tag: item.record_tag};
      end
      OP_INIT: begin
        stk_we    = count > CW'(1);
        stk_waddr = '0;
        stk_wdata = '{lo: '0, hi: count_dec[AW-1:0]};
      end
      OP_POP_D: mem_raddr = stk_rdata.lo;
      OP_PIV:   mem_raddr = lo;
      OP_FWD: begin
        if (status.fwd_le && !status.i_next_hi) mem_raddr = i_inc[AW-1:0];
        else mem_raddr = j;
      end
      OP_BWD:   mem_raddr = j - 1'b1;
      OP_SWAP1: begin
        mem_we    = 1'b1;
        mem_waddr = i;
        mem_wdata = jval;
      end
      OP_SWAP2: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        mem_wdata = ival;
        mem_raddr = i;
      end
      OP_PLACE1: begin
        mem_we    = 1'b1;
        mem_waddr = lo;
        mem_wdata = jval;
      end
      OP_PLACE2: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        mem_wdata = pivot;
      end
      OP_PUSH_R: begin
        stk_we    = ({1'b0, hi} > j_inc) && (sp < CW'(CAPACITY));
        stk_wdata = '{lo: j_inc[AW-1:0], hi: hi};
      end
      OP_PUSH_L: begin
        stk_we    = ({1'b0, j} > lo_inc) && (sp < CW'(CAPACITY));
        stk_wdata = '{lo: lo, hi: j - 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      overflow     <= 1'b0;
      sp           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (status.out_taken) result_valid <= 1'b0;
      case (cmd.op) inside
        OP_LOAD: begin
          if (accept) begin
            if (has_room) count <= count + 1'b1;
            else overflow <= 1'b1;
          end
        end
        OP_INIT: sp <= (count > CW'(1)) ? CW'(1) : '0;
        OP_POP:  if (!status.sp_zero) sp <= sp - 1'b1;
        OP_PUSH_R, OP_PUSH_L: if (stk_we) sp <= sp + 1'b1;
        OP_OUT_LD: result_valid <= 1'b1;
        OP_DONE: begin
          count    <= '0;
          overflow <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // sort registers and output payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: k <= '0;
      OP_POP_D: begin
        lo <= stk_rdata.lo;
        hi <= stk_rdata.hi;
      end
      OP_PIV: begin
        i <= lo;
        j <= hi;
      end
      OP_FWD: begin
        if (status.fwd_le) i <= i_inc[AW-1:0];
        else ival <= mem_rdata;
      end
      OP_BWD: begin
        if (status.bwd_le) j <= j - 1'b1;
        else jval <= mem_rdata;
      end
      OP_OUT_LD: begin
        result.out_tag      <= mem_rdata.tag;
        result.out_train    <= mem_rdata.key.train;
        result.out_arrival  <= mem_rdata.key.arrival;
        result.out_seconds  <= mem_rdata.key.seconds;
        result.dropped_flag <= overflow;
        result.end_of_run   <= {1'b0, k} == count_dec;
        k                   <= k + 1'b1;
      end
      default: ;
    endcase
    if (cmd.op == OP_PIV) pivot <= mem_rdata;
  end
endmodule
`default_nettype wire

// File: hdl/record_quicksort_by_route_key.sv
`default_nettype none
// channel  handshake                    payload   direction
// item     item_valid / item_ready      item      in
// result   result_valid / result_ready  result    out
//
// loading accepts one request per cycle; the last request starts the sort.
// a partition scan makes one compare per cycle on the record ram read port; a swap
// passes CHECK, SWAP1 and SWAP2, a range pop POP and POP_D, a partition PIV to PUSH_L.
// each result passes OUT_RD, OUT_LD and OUT_HOLD, and waits there on result_ready.
// reset empties the store; no request is taken while sorting or draining.
module record_quicksort_by_route_key (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire rqs_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output rqs_pkg::result_t      result
);
  import rqs_pkg::*;

  cmd_t    cmd;
  status_t status;

  rqs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .status(status), .cmd(cmd)
  );

  rqs_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("loading while results pending");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result.end_of_run) |-> ##2 item_ready)
    else $error("block not ready after last result");
endmodule
`default_nettype wire

// File: bench/route_sort_checker.sv
`timescale 1ns / 1ps
module route_sort_checker
  import rqs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      fail_count,
  output int      pending_count
);

  key_t       held_key[CAPACITY];
  logic [15:0] held_tag[CAPACITY];
  int         held_count;
  logic       overflow;
  result_t    sorted_q[$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic key_le(input key_t a, input key_t b);
    if (a.train == b.train && a.arrival != b.arrival) begin
      return a.arrival;
    end
    return a.seconds <= b.seconds;
  endfunction

  task automatic swap_held(input int x, input int y);
    key_t        k;
    logic [15:0] t;
    k = held_key[x];
    t = held_tag[x];
    held_key[x] = held_key[y];
    held_tag[x] = held_tag[y];
    held_key[y] = k;
    held_tag[y] = t;
  endtask

  // first-element pivot quicksort with explicit range stack
  task automatic quicksort_held(input int n);
    int   lo_s[$];
    int   hi_s[$];
    int   lo, hi, i, j;
    key_t pk;
    logic [15:0] pt;
    if (n > 1) begin
      lo_s.push_back(0);
      hi_s.push_back(n - 1);
    end
    while (lo_s.size() > 0) begin
      lo = lo_s.pop_back();
      hi = hi_s.pop_back();
      pk = held_key[lo];
      pt = held_tag[lo];
      i = lo;
      j = hi;
      forever begin
        while (key_le(held_key[i], pk)) begin
          i++;
          if (i == hi) break;
        end
        while (key_le(pk, held_key[j])) begin
          j--;
          if (j == lo) break;
        end
        if (i >= j) break;
        swap_held(i, j);
      end
      held_key[lo] = held_key[j];
      held_tag[lo] = held_tag[j];
      held_key[j] = pk;
      held_tag[j] = pt;
      if (hi > j + 1) begin
        lo_s.push_back(j + 1);
        hi_s.push_back(hi);
      end
      if (j - 1 > lo) begin
        lo_s.push_back(lo);
        hi_s.push_back(j - 1);
      end
    end
  endtask

  task automatic take_request(input item_t it);
    result_t r;
    if (held_count < CAPACITY) begin
      held_key[held_count] = '{train: it.train_number, arrival: it.is_arrival,
                               seconds: it.plan_seconds};
      held_tag[held_count] = it.record_tag;
      held_count++;
    end else begin
      overflow = 1'b1;
    end
    if (it.final_record) begin
      quicksort_held(held_count);
      for (int k = 0; k < held_count; k++) begin
        r.out_tag      = held_tag[k];
        r.out_train    = held_key[k].train;
        r.out_arrival  = held_key[k].arrival;
        r.out_seconds  = held_key[k].seconds;
        r.dropped_flag = overflow;
        r.end_of_run   = (k == held_count - 1);
        sorted_q.push_back(r);
      end
      held_count = 0;
      overflow = 1'b0;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (sorted_q.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    want = sorted_q.pop_front();
    if (got.out_tag !== want.out_tag)
      report($sformatf("tag %h want %h", got.out_tag, want.out_tag));
    if (got.out_train !== want.out_train)
      report($sformatf("train %h want %h", got.out_train, want.out_train));
    if (got.out_arrival !== want.out_arrival)
      report($sformatf("arrival %b want %b", got.out_arrival, want.out_arrival));
    if (got.out_seconds !== want.out_seconds)
      report($sformatf("seconds %h want %h", got.out_seconds, want.out_seconds));
    if (got.dropped_flag !== want.dropped_flag)
      report($sformatf("dropped %b want %b", got.dropped_flag, want.dropped_flag));
    if (got.end_of_run !== want.end_of_run)
      report($sformatf("end_of_run %b want %b", got.end_of_run, want.end_of_run));
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    held_count = 0;
    overflow = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) check_result(result);
      if (item_valid && item_ready) take_request(item);
      pending_count = sorted_q.size();
    end
  end

endmodule

// File: bench/tb_record_quicksort_by_route_key.sv
`timescale 1ns / 1ps
module tb_record_quicksort_by_route_key;
  import rqs_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  int      fail_count;
  int      pending_count;
  logic    quiet_end = 1'b0;
  logic    long_hold = 1'b0;
  int      idle_cycles;

  always #5 clk = ~clk;

  record_quicksort_by_route_key u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  route_sort_checker u_chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        result_ready <= 1'b0;
        while (!result_valid) @(posedge clk);
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet_end && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_request(input item_t it, input logic gaps);
    int n;
    if (gaps && !quiet_end && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  function automatic item_t random_record(input logic fin, input logic [15:0] train_pool);
    item_t it;
    it.record_tag   = 16'($urandom);
    it.train_number = (train_pool == 0) ? 16'($urandom) : 16'($urandom_range(0, train_pool));
    it.is_arrival   = 1'($urandom_range(0, 1));
    it.plan_seconds = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 20);
    it.final_record = fin;
    return it;
  endfunction

  task automatic send_set(input int n, input logic gaps);
    logic [15:0] pool;
    pool = ($urandom_range(0, 1) == 0) ? 16'd3 : 16'd0;
    for (int k = 0; k < n; k++) send_request(random_record(k == n - 1, pool), gaps);
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int    sent;
    int    n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single record, field extremes, equal keys, arrival ordering
    send_request('{record_tag: 16'hFFFF, train_number: 16'hFFFF, is_arrival: 1'b1,
                   plan_seconds: 32'hFFFF_FFFF, final_record: 1'b1}, 1'b0);
    send_request('{16'h0000, 16'h0000, 1'b0, 32'h0, 1'b0}, 1'b0);
    send_request('{16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b0);
    send_request('{16'h1234, 16'h0007, 1'b0, 32'd5, 1'b0}, 1'b0);
    send_request('{16'h4321, 16'h0007, 1'b1, 32'd9, 1'b0}, 1'b0);
    send_request('{16'h5555, 16'h0007, 1'b1, 32'd9, 1'b0}, 1'b0);
    send_request('{16'hAAAA, 16'h0008, 1'b0, 32'd5, 1'b1}, 1'b0);
    drain();
    // sender pauses until every expected result has come
    send_request('{16'h0101, 16'h0002, 1'b0, 32'd3, 1'b0}, 1'b0);
    send_request('{16'h0202, 16'h0002, 1'b0, 32'd1, 1'b1}, 1'b0);
    drain();

    // overflow: fill past capacity, last of the extras is final; receiver holds off
    // while the next set keeps being offered
    long_hold = 1'b1;
    for (int k = 0; k < CAPACITY + 3; k++)
      send_request(random_record(k == CAPACITY + 2, 16'd0), 1'b0);
    send_set(5, 1'b0);
    drain();
    sent = 9 + CAPACITY + 3 + 5;

    // random sets, mostly small, a few at full size
    while (sent < 170) begin
      n = ($urandom_range(0, 9) == 0) ? CAPACITY : $urandom_range(1, 8);
      if (sent > 140) quiet_end = 1'b1;
      send_set(n, 1'b1);
      sent += n;
    end
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
hdl/rqs_pkg.sv
hdl/rqs_ram.sv
hdl/rqs_ctrl.sv
hdl/rqs_dp.sv
hdl/record_quicksort_by_route_key.sv
bench/route_sort_checker.sv
bench/tb_record_quicksort_by_route_key.sv
